// File: rtl/bmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types, codes and constants of the button menu controller.
// ----------------------------------------------------------------------------
package bmc_pkg;

   // press kinds
   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_SHORT     = 2'd1;
   localparam logic [1:0] KIND_LONG      = 2'd2;
   localparam logic [1:0] KIND_VERY_LONG = 2'd3;

   // menu states
   localparam logic [2:0] MENU_OFF     = 3'd0;
   localparam logic [2:0] MENU_BATTERY = 3'd1;
   localparam logic [2:0] MENU_MOIST   = 3'd2;
   localparam logic [2:0] MENU_MANUAL  = 3'd3;
   localparam logic [2:0] MENU_SEL_THR = 3'd4;
   localparam logic [2:0] MENU_SEL_MUL = 3'd5;
   localparam logic [2:0] MENU_CHG_THR = 3'd6;
   localparam logic [2:0] MENU_CHG_MUL = 3'd7;

   // transition codes
   localparam logic [3:0] CHG_NONE            = 4'd0;
   localparam logic [3:0] CHG_OFF_TO_BATT     = 4'd1;
   localparam logic [3:0] CHG_BATT_TO_SELTHR  = 4'd2;
   localparam logic [3:0] CHG_BATT_TO_MOIST   = 4'd3;
   localparam logic [3:0] CHG_MOIST_TO_MANUAL = 4'd4;
   localparam logic [3:0] CHG_MOIST_TO_BATT   = 4'd5;
   localparam logic [3:0] CHG_MANUAL_TO_MOIST = 4'd6;
   localparam logic [3:0] CHG_SELTHR_TO_SELMUL = 4'd7;
   localparam logic [3:0] CHG_SELTHR_TO_CHGTHR = 4'd8;
   localparam logic [3:0] CHG_SELMUL_TO_SELTHR = 4'd9;
   localparam logic [3:0] CHG_SELMUL_TO_CHGMUL = 4'd10;
   localparam logic [3:0] CHG_LEVEL_STEP      = 4'd11;
   localparam logic [3:0] CHG_MULT_STEP       = 4'd12;
   localparam logic [3:0] CHG_CONFIRM_OFF     = 4'd13;
   localparam logic [3:0] CHG_SHUTDOWN        = 4'd14;
   localparam logic [3:0] CHG_TIMEOUT         = 4'd15;

   // register indexes
   localparam logic [1:0] REG_TICK_MS      = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_SEC  = 2'd1;
   localparam logic [1:0] REG_LONG_TICKS   = 2'd2;
   localparam logic [1:0] REG_OFF_TICKS    = 2'd3;

   // register reset values
   localparam logic [9:0] TICK_MS_RST     = 10'd10;
   localparam logic [7:0] TIMEOUT_SEC_RST = 8'd30;
   localparam logic [9:0] LONG_TICKS_RST  = 10'd75;
   localparam logic [9:0] OFF_TICKS_RST   = 10'd300;

   // fixed limits
   localparam logic [9:0]  COUNT_MAX       = 10'd1023;
   localparam logic [9:0]  SHORT_MIN_TICKS = 10'd2;
   localparam logic [3:0]  LEVEL_MAX       = 4'd8;
   localparam logic [2:0]  MULT_MAX        = 3'd5;
   localparam logic [10:0] MS_PER_SECOND   = 11'd1000;
   localparam logic [7:0]  SEC_MAX         = 8'd255;
   localparam logic [3:0]  LEVEL_RST       = 4'd4;
   localparam logic [2:0]  MULT_RST        = 3'd1;

   typedef struct packed {
      logic [9:0] tick_ms;
      logic [7:0] timeout_seconds;
      logic [9:0] long_press_ticks;
      logic [9:0] off_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic       pressed;
      logic [1:0] kind;
   } press_type;

   typedef struct packed {
      logic [2:0] menu_state;
      logic [3:0] change_code;
      logic [1:0] press_kind;
      logic [3:0] level_out;
      logic [2:0] mult_out;
      logic       save_level;
      logic       save_mult;
   } result_type;

endpackage

// File: rtl/bmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_if
// Valid/ready channels of the button menu controller: tick and result.
// ----------------------------------------------------------------------------
interface bmc_req_if;
   logic valid;
   logic ready;
   logic button_level;
   logic valve_open;

   modport source (output valid, output button_level, output valve_open, input ready);
   modport sink   (input valid, input button_level, input valve_open, output ready);
endinterface

interface bmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] menu_state;
   logic [3:0] change_code;
   logic [1:0] press_kind;
   logic [3:0] level_out;
   logic [2:0] mult_out;
   logic       save_level;
   logic       save_mult;

   modport source (output valid, output menu_state, output change_code, output press_kind,
                   output level_out, output mult_out, output save_level, output save_mult,
                   input ready);
   modport sink   (input valid, input menu_state, input change_code, input press_kind,
                   input level_out, input mult_out, input save_level, input save_mult,
                   output ready);
endinterface

// File: rtl/bmc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_classify
// Press classifier: counts held ticks and reports short, long, very long.
// ----------------------------------------------------------------------------
module bmc_classify (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                pressed,
   input  bmc_pkg::cfg_type    cfg,
   output bmc_pkg::press_type  press
);

   logic [9:0] press_count_ff, press_count_in;
   logic [9:0] hold_count_ff,  hold_count_in;
   logic       long_given_ff,  long_given_in;
   logic [9:0] press_inc, hold_inc;
   logic       hit_long, hit_off;
   logic [1:0] kind;

   // saturating increments
   assign press_inc = (press_count_ff == bmc_pkg::COUNT_MAX) ? press_count_ff
                                                             : press_count_ff + 10'd1;
   assign hold_inc  = (hold_count_ff == bmc_pkg::COUNT_MAX) ? hold_count_ff
                                                            : hold_count_ff + 10'd1;
   assign hit_long  = (press_inc >= cfg.long_press_ticks) && !long_given_ff;
   assign hit_off   = (hold_inc >= cfg.off_press_ticks);

   always_comb begin
      kind           = bmc_pkg::KIND_NONE;
      press_count_in = 10'd0;
      hold_count_in  = 10'd0;
      long_given_in  = 1'b0;
      if (pressed) begin
         press_count_in = hit_long ? 10'd0 : press_inc;
         hold_count_in  = hit_off  ? 10'd0 : hold_inc;
         long_given_in  = long_given_ff | hit_long;
         if (hit_off) begin
            kind = bmc_pkg::KIND_VERY_LONG;
         end else if (hit_long) begin
            kind = bmc_pkg::KIND_LONG;
         end
      end else if (!long_given_ff && (press_count_ff >= bmc_pkg::SHORT_MIN_TICKS)) begin
         kind = bmc_pkg::KIND_SHORT;
      end
   end

   assign press.pressed = pressed;
   assign press.kind    = kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_count_ff <= 10'd0;
         hold_count_ff  <= 10'd0;
         long_given_ff  <= 1'b0;
      end else if (advance) begin
         press_count_ff <= press_count_in;
         hold_count_ff  <= hold_count_in;
         long_given_ff  <= long_given_in;
      end
   end

endmodule

// File: rtl/bmc_menu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_menu
// Menu state machine with level/multiplier settings and idle timeout.
// ----------------------------------------------------------------------------
module bmc_menu (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                valve_open,
   input  bmc_pkg::press_type  press,
   input  bmc_pkg::cfg_type    cfg,
   output bmc_pkg::result_type result
);

   logic [2:0]  menu_ff,  menu_in;
   logic [3:0]  level_ff, level_in;
   logic [2:0]  mult_ff,  mult_in;
   logic [10:0] ms_ff,    ms_in;
   logic [7:0]  sec_ff,   sec_in;

   logic [2:0]  menu_step;
   logic [3:0]  code_step;
   logic [3:0]  code;
   logic        sv_level, sv_mult;
   logic        sh, lg;
   logic [10:0] ms_base, ms_sum;
   logic [7:0]  sec_base, sec_tmp;

   assign sh = (press.kind == bmc_pkg::KIND_SHORT);
   assign lg = (press.kind == bmc_pkg::KIND_LONG);

   // menu step on the classified press
   always_comb begin
      menu_step = menu_ff;
      code_step = bmc_pkg::CHG_NONE;
      level_in  = level_ff;
      mult_in   = mult_ff;
      sv_level  = 1'b0;
      sv_mult   = 1'b0;
      if (sh || lg) begin
         case (menu_ff)
            bmc_pkg::MENU_OFF: begin
               menu_step = bmc_pkg::MENU_BATTERY;
               code_step = bmc_pkg::CHG_OFF_TO_BATT;
            end
            bmc_pkg::MENU_BATTERY: begin
               if (lg) begin
                  menu_step = bmc_pkg::MENU_SEL_THR;
                  code_step = bmc_pkg::CHG_BATT_TO_SELTHR;
               end else begin
                  menu_step = bmc_pkg::MENU_MOIST;
                  code_step = bmc_pkg::CHG_BATT_TO_MOIST;
               end
            end
            bmc_pkg::MENU_MOIST: begin
               if (lg && !valve_open) begin
                  menu_step = bmc_pkg::MENU_MANUAL;
                  code_step = bmc_pkg::CHG_MOIST_TO_MANUAL;
               end else if (sh) begin
                  menu_step = bmc_pkg::MENU_BATTERY;
                  code_step = bmc_pkg::CHG_MOIST_TO_BATT;
               end
            end
            bmc_pkg::MENU_MANUAL: begin
               if (valve_open) begin
                  menu_step = bmc_pkg::MENU_MOIST;
                  code_step = bmc_pkg::CHG_MANUAL_TO_MOIST;
               end
            end
            bmc_pkg::MENU_SEL_THR: begin
               if (sh) begin
                  menu_step = bmc_pkg::MENU_SEL_MUL;
                  code_step = bmc_pkg::CHG_SELTHR_TO_SELMUL;
               end else begin
                  menu_step = bmc_pkg::MENU_CHG_THR;
                  code_step = bmc_pkg::CHG_SELTHR_TO_CHGTHR;
               end
            end
            bmc_pkg::MENU_SEL_MUL: begin
               if (sh) begin
                  menu_step = bmc_pkg::MENU_SEL_THR;
                  code_step = bmc_pkg::CHG_SELMUL_TO_SELTHR;
               end else begin
                  menu_step = bmc_pkg::MENU_CHG_MUL;
                  code_step = bmc_pkg::CHG_SELMUL_TO_CHGMUL;
               end
            end
            bmc_pkg::MENU_CHG_THR: begin
               if (sh) begin
                  level_in  = (level_ff >= bmc_pkg::LEVEL_MAX) ? 4'd1 : level_ff + 4'd1;
                  code_step = bmc_pkg::CHG_LEVEL_STEP;
                  sv_level  = 1'b1;
               end else begin
                  menu_step = bmc_pkg::MENU_OFF;
                  code_step = bmc_pkg::CHG_CONFIRM_OFF;
               end
            end
            default: begin
               if (sh) begin
                  mult_in   = (mult_ff >= bmc_pkg::MULT_MAX) ? 3'd1 : mult_ff + 3'd1;
                  code_step = bmc_pkg::CHG_MULT_STEP;
                  sv_mult   = 1'b1;
               end else begin
                  menu_step = bmc_pkg::MENU_OFF;
                  code_step = bmc_pkg::CHG_CONFIRM_OFF;
               end
            end
         endcase
      end else if (press.kind == bmc_pkg::KIND_VERY_LONG) begin
         menu_step = bmc_pkg::MENU_OFF;
         code_step = bmc_pkg::CHG_SHUTDOWN;
      end
   end

   // idle timeout, acting after the menu step; a press clears the counters
   assign ms_base  = press.pressed ? 11'd0 : ms_ff;
   assign sec_base = press.pressed ? 8'd0  : sec_ff;
   assign ms_sum   = ms_base + {1'b0, cfg.tick_ms};

   always_comb begin
      menu_in = menu_step;
      code    = code_step;
      ms_in   = 11'd0;
      sec_in  = 8'd0;
      sec_tmp = sec_base;
      if (menu_step != bmc_pkg::MENU_OFF) begin
         if (ms_sum >= bmc_pkg::MS_PER_SECOND) begin
            sec_tmp = (sec_base == bmc_pkg::SEC_MAX) ? sec_base : sec_base + 8'd1;
            ms_in   = 11'd0;
         end else begin
            ms_in   = ms_sum;
         end
         sec_in = sec_tmp;
         if (sec_tmp >= cfg.timeout_seconds) begin
            menu_in = bmc_pkg::MENU_OFF;
            code    = bmc_pkg::CHG_TIMEOUT;
            sec_in  = 8'd0;
            ms_in   = 11'd0;
         end
      end
   end

   assign result.menu_state  = menu_in;
   assign result.change_code = code;
   assign result.press_kind  = press.kind;
   assign result.level_out   = level_in;
   assign result.mult_out    = mult_in;
   assign result.save_level  = sv_level;
   assign result.save_mult   = sv_mult;

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_ff  <= bmc_pkg::MENU_OFF;
         level_ff <= bmc_pkg::LEVEL_RST;
         mult_ff  <= bmc_pkg::MULT_RST;
         ms_ff    <= 11'd0;
         sec_ff   <= 8'd0;
      end else if (advance) begin
         menu_ff  <= menu_in;
         level_ff <= level_in;
         mult_ff  <= mult_in;
         ms_ff    <= ms_in;
         sec_ff   <= sec_in;
      end
   end

endmodule

// File: rtl/button_menu_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_menu_controller_unit
// Per-tick button classifier, menu sequencer and idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one main-loop tick per transfer: the sampled switch level
//   and the valve state. rsp_if returns exactly one result per tick: menu
//   state, transition code, press kind, level and multiplier settings and
//   the two save strobes.
//   csr_* is a plain write port: tick length in ms, idle timeout in seconds,
//   long and very long press thresholds in ticks. Write only while idle.
//   Flow: an accepted tick waits in the input register, then loads the result
//   register, from which it can transfer. Throughput: one tick per cycle
//   while the receiver takes results; the tick state advances as
//   the input register drains into the result register, so a tick that
//   follows back to back already sees the updated state.
//   Reset (synchronous, active high) clears both stages, sets the menu off,
//   level 4, multiplier 1, counters zero and the registers to their defaults.
//   When the receiver stalls, the result register holds, the input register
//   fills with one more tick, and req_if.ready then drops until space frees.
// ----------------------------------------------------------------------------
module button_menu_controller_unit (
   input  logic        clock,
   input  logic        reset,
   bmc_req_if.sink     req_if,
   bmc_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_write_data
);

   // configuration registers
   bmc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms          <= bmc_pkg::TICK_MS_RST;
         cfg_ff.timeout_seconds  <= bmc_pkg::TIMEOUT_SEC_RST;
         cfg_ff.long_press_ticks <= bmc_pkg::LONG_TICKS_RST;
         cfg_ff.off_press_ticks  <= bmc_pkg::OFF_TICKS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            bmc_pkg::REG_TICK_MS:     cfg_ff.tick_ms          <= csr_write_data;
            bmc_pkg::REG_TIMEOUT_SEC: cfg_ff.timeout_seconds  <= csr_write_data[7:0];
            bmc_pkg::REG_LONG_TICKS:  cfg_ff.long_press_ticks <= csr_write_data;
            bmc_pkg::REG_OFF_TICKS:   cfg_ff.off_press_ticks  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   logic in_valid_ff;
   logic in_level_ff;
   logic in_valve_ff;
   logic out_valid_ff;
   logic advance;
   logic take;

   // advance the input stage when the result register is free or drains now
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign take          = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_level_ff <= req_if.button_level;
         in_valve_ff <= req_if.valve_open;
      end
   end

   // per-tick logic
   bmc_pkg::press_type  press;
   bmc_pkg::result_type result;

   bmc_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pressed (in_level_ff),
      .cfg     (cfg_ff),
      .press   (press)
   );

   bmc_menu u_menu (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .valve_open (in_valve_ff),
      .press      (press),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // result register
   bmc_pkg::result_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.menu_state  = out_ff.menu_state;
   assign rsp_if.change_code = out_ff.change_code;
   assign rsp_if.press_kind  = out_ff.press_kind;
   assign rsp_if.level_out   = out_ff.level_out;
   assign rsp_if.mult_out    = out_ff.mult_out;
   assign rsp_if.save_level  = out_ff.save_level;
   assign rsp_if.save_mult   = out_ff.save_mult;

endmodule
